/* rtl/core/bsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types, codes and reset values of the bank switching mapper.
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int MEM_ADDR_BITS_DEF = 21;
	localparam int MEM_ADDR_BITS_MAX = 24;

	localparam int PRG_W   = 21;
	localparam int CHR_W   = 18;
	localparam int CNT_W   = 9;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 21;

	typedef enum logic [1:0] {
		REQ_CPU_RD = 2'd0,
		REQ_CPU_WR = 2'd1,
		REQ_PPU_RD = 2'd2,
		REQ_PPU_WR = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_WRAM = 2'd1,
		TGT_PRG  = 2'd2,
		TGT_CHR  = 2'd3
	} target_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM_MASK     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_MEM_MASK     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_IS_RAM       = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ALT_IRQ          = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PRG_OUTER_OFFSET = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_OUTER_OFFSET = 4'd7;

	// register write regions, cpu address bits 14:13
	localparam logic [1:0] REG_BANK   = 2'd0;
	localparam logic [1:0] REG_MIRROR = 2'd1;
	localparam logic [1:0] REG_RELOAD = 2'd2;
	localparam logic [1:0] REG_IRQ    = 2'd3;

	localparam logic [2:0] SEL_PRG_A = 3'd6;
	localparam logic [2:0] SEL_PRG_B = 3'd7;
	localparam int         CHR_BANKS = 6;

	localparam logic [PRG_W-1:0] PRG_ROM_MASK_RST   = 21'h007FFF;
	localparam logic [CHR_W-1:0] CHR_MEM_MASK_RST   = 18'h01FFF;
	localparam logic [CNT_W-1:0] PRG_BANK_COUNT_RST = 9'd4;
	localparam logic [7:0]       RELOAD_VALUE_RST   = 8'hFF;

endpackage

/* rtl/core/bsm_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_req_if
// Bus access channel into the mapper.
// ----------------------------------------------------------------------------
interface bsm_req_if
	import bsm_pkg::*;
();
	logic      valid;
	logic      ready;
	req_type_t req_type;
	logic [15:0] bus_addr;
	logic [7:0]  bus_data;

	modport source (output valid, req_type, bus_addr, bus_data, input ready);
	modport sink   (input valid, req_type, bus_addr, bus_data, output ready);
endinterface

/* rtl/core/bsm_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_rsp_if
// Translated access channel out of the mapper.
// ----------------------------------------------------------------------------
interface bsm_rsp_if
	import bsm_pkg::*;
#(
	parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) ();
	logic    valid;
	logic    ready;
	target_t target;
	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic    mem_write;
	logic    mirror_horizontal;
	logic    irq_line;

	modport source (output valid, target, mem_addr, mem_write, mirror_horizontal, irq_line,
		input ready);
	modport sink   (input valid, target, mem_addr, mem_write, mirror_horizontal, irq_line,
		output ready);
endinterface

/* rtl/core/bsm_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface bsm_cfg_if
	import bsm_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] reg_data;

	modport source (output valid, reg_index, reg_data, input ready);
	modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

/* rtl/core/bank_switch_mapper_with_line_irq.sv */
`timescale 1ns / 1ps
// Bus access mapper with scanline interrupt. One access is taken every clock
// while the result side keeps up: an access is held in the input register,
// is translated and applied to the mapper state as it moves into the result
// register, and is presented to the result side from that register.
// A result that is not taken stops the input only once the input register
// also holds an item; the input then stalls until the result side takes the
// waiting item. Configuration writes are taken at any time and always
// complete in the cycle they are offered.
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_line_irq
// Translates cpu and ppu accesses into work ram, program rom and pattern
// memory addresses; keeps bank, mirroring and scanline counter state.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_line_irq
	import bsm_pkg::*;
#(
	parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bsm_req_if.sink    req,
	bsm_rsp_if.source  rsp,
	bsm_cfg_if.sink    cfg
);

	// configuration
	logic [PRG_W-1:0] prg_rom_mask_q;
	logic [CHR_W-1:0] chr_mem_mask_q;
	logic [CNT_W-1:0] prg_bank_count_q;
	logic             chr_is_ram_q;
	logic             alt_irq_q;
	logic             four_screen_q;
	logic [PRG_W-1:0] prg_outer_offset_q;
	logic [CHR_W-1:0] chr_outer_offset_q;

	// mapper state
	logic [7:0] chr_bank_q [CHR_BANKS];
	logic [7:0] prg_bank_a_q;
	logic [7:0] prg_bank_b_q;
	logic [2:0] bank_select_q;
	logic       chr_swap_q;
	logic       prg_swap_q;
	logic       mirror_bit_q;
	logic [7:0] line_counter_q;
	logic [7:0] reload_value_q;
	logic       irq_enabled_q;
	logic       reload_pending_q;
	logic       irq_pending_q;
	logic       last_a12_q;

	// input stage
	logic        valid_s1;
	req_type_t   req_type_s1;
	logic [15:0] bus_addr_s1;
	logic [7:0]  bus_data_s1;

	// result stage
	logic                     valid_s2;
	target_t                  target_s2;
	logic [MEM_ADDR_BITS-1:0] mem_addr_s2;
	logic                     mem_write_s2;
	logic                     mirror_s2;
	logic                     irq_s2;

	logic advance;
	logic step;

	assign advance   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	// next state and result of the item in the input stage
	logic [7:0] chr_bank_d [CHR_BANKS];
	logic [7:0] prg_bank_a_d;
	logic [7:0] prg_bank_b_d;
	logic [2:0] bank_select_d;
	logic       chr_swap_d;
	logic       prg_swap_d;
	logic       mirror_bit_d;
	logic [7:0] line_counter_d;
	logic [7:0] reload_value_d;
	logic       irq_enabled_d;
	logic       reload_pending_d;
	logic       irq_pending_d;
	logic       last_a12_d;

	target_t                      target_d;
	logic [MEM_ADDR_BITS_MAX-1:0] addr_wide;
	logic                         mem_write_d;

	logic [CNT_W-1:0] last_bank;
	logic [CNT_W-1:0] second_bank;
	logic [CNT_W-1:0] prg_base;
	logic [PRG_W-1:0] prg_addr;

	logic [12:0]      chr_a;
	logic [2:0]       chr_idx;
	logic [7:0]       chr_sel;
	logic [CHR_W-1:0] chr_off;
	logic [CHR_W-1:0] chr_addr;

	logic       a12;
	logic [7:0] cnt_new;

	assign last_bank   = prg_bank_count_q - 9'd1;
	assign second_bank = prg_bank_count_q - 9'd2;

	always_comb begin
		unique case (bus_addr_s1[14:13])
			2'd0:    prg_base = prg_swap_q ? second_bank : {1'b0, prg_bank_a_q};
			2'd1:    prg_base = {1'b0, prg_bank_b_q};
			2'd2:    prg_base = prg_swap_q ? {1'b0, prg_bank_a_q} : second_bank;
			default: prg_base = last_bank;
		endcase
	end

	assign prg_addr = ({prg_base[7:0], bus_addr_s1[12:0]} & prg_rom_mask_q)
		| prg_outer_offset_q;

	assign chr_a   = {bus_addr_s1[12] ^ chr_swap_q, bus_addr_s1[11:0]};
	assign chr_idx = chr_a[12] ? (3'd2 + {1'b0, chr_a[11:10]}) : {2'b0, chr_a[11]};
	assign chr_sel = chr_bank_q[chr_idx];
	assign chr_off = chr_a[12] ? {chr_sel, chr_a[9:0]} : {chr_sel[7:1], chr_a[10:0]};
	assign chr_addr = chr_is_ram_q ? {5'b0, chr_off[12:0]}
		: ((chr_off & chr_mem_mask_q) | chr_outer_offset_q);

	assign a12     = bus_addr_s1[12];
	assign cnt_new = (line_counter_q == 8'd0 || reload_pending_q) ? reload_value_q
		: line_counter_q - 8'd1;

	always_comb begin
		chr_bank_d       = chr_bank_q;
		prg_bank_a_d     = prg_bank_a_q;
		prg_bank_b_d     = prg_bank_b_q;
		bank_select_d    = bank_select_q;
		chr_swap_d       = chr_swap_q;
		prg_swap_d       = prg_swap_q;
		mirror_bit_d     = mirror_bit_q;
		line_counter_d   = line_counter_q;
		reload_value_d   = reload_value_q;
		irq_enabled_d    = irq_enabled_q;
		reload_pending_d = reload_pending_q;
		irq_pending_d    = irq_pending_q;
		last_a12_d       = last_a12_q;
		target_d         = TGT_NONE;
		addr_wide        = '0;
		mem_write_d      = 1'b0;

		unique case (req_type_s1)
			REQ_CPU_RD, REQ_CPU_WR: begin
				if (bus_addr_s1[15:13] == 3'b011) begin
					target_d    = TGT_WRAM;
					addr_wide   = {{(MEM_ADDR_BITS_MAX-13){1'b0}}, bus_addr_s1[12:0]};
					mem_write_d = (req_type_s1 == REQ_CPU_WR);
				end else if (bus_addr_s1[15] && req_type_s1 == REQ_CPU_RD) begin
					target_d  = TGT_PRG;
					addr_wide = {{(MEM_ADDR_BITS_MAX-PRG_W){1'b0}}, prg_addr};
				end else if (bus_addr_s1[15]) begin
					unique case (bus_addr_s1[14:13])
						REG_BANK: begin
							if (!bus_addr_s1[0]) begin
								chr_swap_d    = bus_data_s1[7];
								prg_swap_d    = bus_data_s1[6];
								bank_select_d = bus_data_s1[2:0];
							end else if (bank_select_q == SEL_PRG_A) begin
								prg_bank_a_d = bus_data_s1;
							end else if (bank_select_q == SEL_PRG_B) begin
								prg_bank_b_d = bus_data_s1;
							end else begin
								for (int i = 0; i < CHR_BANKS; i++) begin
									if (bank_select_q == 3'(i))
										chr_bank_d[i] = bus_data_s1;
								end
							end
						end
						REG_MIRROR: begin
							if (!bus_addr_s1[0] && !four_screen_q)
								mirror_bit_d = bus_data_s1[0];
						end
						REG_RELOAD: begin
							if (!bus_addr_s1[0]) begin
								reload_value_d = bus_data_s1;
							end else begin
								line_counter_d   = 8'd0;
								reload_pending_d = 1'b1;
							end
						end
						REG_IRQ: begin
							if (!bus_addr_s1[0]) begin
								irq_enabled_d = 1'b0;
								irq_pending_d = 1'b0;
							end else begin
								irq_enabled_d = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			REQ_PPU_RD, REQ_PPU_WR: begin
				last_a12_d = a12;
				if (a12 && !last_a12_q) begin
					line_counter_d   = cnt_new;
					reload_pending_d = 1'b0;
					if ((!alt_irq_q || line_counter_q != 8'd0 || reload_pending_q)
						&& cnt_new == 8'd0 && irq_enabled_q)
						irq_pending_d = 1'b1;
				end
				if (!bus_addr_s1[13]) begin
					target_d    = TGT_CHR;
					addr_wide   = {{(MEM_ADDR_BITS_MAX-CHR_W){1'b0}}, chr_addr};
					mem_write_d = (req_type_s1 == REQ_PPU_WR) && chr_is_ram_q;
				end
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_rom_mask_q     <= PRG_ROM_MASK_RST;
			chr_mem_mask_q     <= CHR_MEM_MASK_RST;
			prg_bank_count_q   <= PRG_BANK_COUNT_RST;
			chr_is_ram_q       <= 1'b1;
			alt_irq_q          <= 1'b0;
			four_screen_q      <= 1'b0;
			prg_outer_offset_q <= '0;
			chr_outer_offset_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				CFG_PRG_ROM_MASK:     prg_rom_mask_q     <= cfg.reg_data[PRG_W-1:0];
				CFG_CHR_MEM_MASK:     chr_mem_mask_q     <= cfg.reg_data[CHR_W-1:0];
				CFG_PRG_BANK_COUNT:   prg_bank_count_q   <= cfg.reg_data[CNT_W-1:0];
				CFG_CHR_IS_RAM:       chr_is_ram_q       <= cfg.reg_data[0];
				CFG_ALT_IRQ:          alt_irq_q          <= cfg.reg_data[0];
				CFG_FOUR_SCREEN:      four_screen_q      <= cfg.reg_data[0];
				CFG_PRG_OUTER_OFFSET: prg_outer_offset_q <= cfg.reg_data[PRG_W-1:0];
				CFG_CHR_OUTER_OFFSET: chr_outer_offset_q <= cfg.reg_data[CHR_W-1:0];
				default: ;
			endcase
		end
	end

	// mapper state, updated as an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHR_BANKS; i++)
				chr_bank_q[i] <= 8'd0;
			prg_bank_a_q     <= 8'd0;
			prg_bank_b_q     <= 8'd0;
			bank_select_q    <= 3'd0;
			chr_swap_q       <= 1'b0;
			prg_swap_q       <= 1'b0;
			mirror_bit_q     <= 1'b0;
			line_counter_q   <= 8'd0;
			reload_value_q   <= RELOAD_VALUE_RST;
			irq_enabled_q    <= 1'b0;
			reload_pending_q <= 1'b0;
			irq_pending_q    <= 1'b0;
			last_a12_q       <= 1'b0;
		end else if (step) begin
			chr_bank_q       <= chr_bank_d;
			prg_bank_a_q     <= prg_bank_a_d;
			prg_bank_b_q     <= prg_bank_b_d;
			bank_select_q    <= bank_select_d;
			chr_swap_q       <= chr_swap_d;
			prg_swap_q       <= prg_swap_d;
			mirror_bit_q     <= mirror_bit_d;
			line_counter_q   <= line_counter_d;
			reload_value_q   <= reload_value_d;
			irq_enabled_q    <= irq_enabled_d;
			reload_pending_q <= reload_pending_d;
			irq_pending_q    <= irq_pending_d;
			last_a12_q       <= last_a12_d;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1 <= req.req_type;
			bus_addr_s1 <= req.bus_addr;
			bus_data_s1 <= req.bus_data;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			target_s2    <= target_d;
			mem_addr_s2  <= addr_wide[MEM_ADDR_BITS-1:0];
			mem_write_s2 <= mem_write_d;
			mirror_s2    <= mirror_bit_d;
			irq_s2       <= irq_pending_d;
		end
	end

	assign rsp.valid             = valid_s2;
	assign rsp.target            = target_s2;
	assign rsp.mem_addr          = mem_addr_s2;
	assign rsp.mem_write         = mem_write_s2;
	assign rsp.mirror_horizontal = mirror_s2;
	assign rsp.irq_line          = irq_s2;

`ifndef SYNTHESIS
	a_irq_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		irq_pending_q |-> irq_enabled_q)
		else $error("interrupt pending while disabled");

	a_reload_clears_counter: assert property (@(posedge clk) disable iff (!arst_n)
		reload_pending_q |-> (line_counter_q == 8'd0))
		else $error("reload pending with nonzero counter");

	a_unmapped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && target_s2 == TGT_NONE) |-> (mem_addr_s2 == '0 && !mem_write_s2))
		else $error("unmapped item carries address or write");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> req.ready)
		else $error("input stalled with empty result stage");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bank switching mapper. Every bus access that
// is handed over is run through a local model of the banking, mirroring and
// scanline counter logic, and each translated item that comes back is held
// against the oldest prediction. A short directed table is walked first,
// then randomised phases under several configurations and idling patterns,
// two of them with a long output hold-off that backs up the input side.
// ----------------------------------------------------------------------------
module tb;
	import bsm_pkg::*;

	localparam int ADDR_W        = MEM_ADDR_BITS_DEF;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_ITEMS   = 205;

	typedef struct {
		target_t           target;
		logic [ADDR_W-1:0] mem_addr;
		logic              mem_write;
		logic              mirror_horizontal;
		logic              irq_line;
	} xlat_t;

	typedef struct {
		bit                    cfg_row;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		req_type_t             kind;
		logic [15:0]           addr;
		logic [7:0]            data;
		bit                    typed;
		xlat_t                 want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bsm_req_if                         req_if ();
	bsm_rsp_if #(.MEM_ADDR_BITS(ADDR_W)) rsp_if ();
	bsm_cfg_if                         cfg_if ();

	bank_switch_mapper_with_line_irq #(.MEM_ADDR_BITS(ADDR_W)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// model configuration
	logic [PRG_W-1:0] cfg_prg_mask;
	logic [CHR_W-1:0] cfg_chr_mask;
	logic [CNT_W-1:0] cfg_bank_count;
	logic             cfg_chr_ram;
	logic             cfg_alt_irq;
	logic             cfg_four_screen;
	logic [PRG_W-1:0] cfg_prg_offset;
	logic [CHR_W-1:0] cfg_chr_offset;

	// model state
	logic [7:0] chr_page [CHR_BANKS];
	logic [7:0] prg_page_lo;
	logic [7:0] prg_page_mid;
	logic [2:0] page_sel;
	logic       chr_flip;
	logic       prg_flip;
	logic       mirror_h;
	logic [7:0] line_cnt;
	logic [7:0] line_reload;
	logic       irq_en;
	logic       reload_req;
	logic       irq_flag;
	logic       a12_prev;

	xlat_t     xlat_due [$];
	stim_row_t plan [$];
	int        err_cnt      = 0;
	int        cycle_cnt    = 0;
	int        tx_idle_pct  = 0;
	int        rx_stall_pct = 0;
	bit        hold_kick    = 1'b0;

	function automatic xlat_t translate_access(req_type_t kind, logic [15:0] a, logic [7:0] v);
		xlat_t      x;
		logic [13:0] pa;
		logic [12:0] ca;
		logic [7:0]  b;
		logic [17:0] off;
		logic [8:0]  last_pg;
		logic [8:0]  second_pg;
		logic [21:0] base;
		logic [7:0]  prior;
		logic        was_req;
		x.target    = TGT_NONE;
		x.mem_addr  = '0;
		x.mem_write = 1'b0;
		if (kind == REQ_CPU_RD || kind == REQ_CPU_WR) begin
			if (a >= 16'h6000 && a < 16'h8000) begin
				x.target    = TGT_WRAM;
				x.mem_addr  = ADDR_W'(a[12:0]);
				x.mem_write = (kind == REQ_CPU_WR);
			end else if (a >= 16'h8000 && kind == REQ_CPU_RD) begin
				last_pg   = cfg_bank_count - 9'd1;
				second_pg = cfg_bank_count - 9'd2;
				if (a < 16'hA000)
					base = prg_flip ? {second_pg, 13'b0} : {1'b0, prg_page_lo, 13'b0};
				else if (a < 16'hC000)
					base = {1'b0, prg_page_mid, 13'b0};
				else if (a < 16'hE000)
					base = prg_flip ? {1'b0, prg_page_lo, 13'b0} : {second_pg, 13'b0};
				else
					base = {last_pg, 13'b0};
				base = base + 22'(a[12:0]);
				x.target   = TGT_PRG;
				x.mem_addr = (base[20:0] & cfg_prg_mask) | cfg_prg_offset;
			end else if (a >= 16'h8000) begin
				case (a[14:13])
					REG_BANK: begin
						if (!a[0]) begin
							chr_flip = v[7];
							prg_flip = v[6];
							page_sel = v[2:0];
						end else if (page_sel < SEL_PRG_A) begin
							chr_page[page_sel] = v;
						end else if (page_sel == SEL_PRG_A) begin
							prg_page_lo = v;
						end else begin
							prg_page_mid = v;
						end
					end
					REG_MIRROR: begin
						if (!a[0] && !cfg_four_screen)
							mirror_h = v[0];
					end
					REG_RELOAD: begin
						if (!a[0]) begin
							line_reload = v;
						end else begin
							line_cnt   = 8'd0;
							reload_req = 1'b1;
						end
					end
					REG_IRQ: begin
						if (!a[0]) begin
							irq_en   = 1'b0;
							irq_flag = 1'b0;
						end else begin
							irq_en = 1'b1;
						end
					end
				endcase
			end
		end else begin
			pa = a[13:0];
			// counter clocks on a rising a12, mapped or not
			if (pa[12] && !a12_prev) begin
				prior   = line_cnt;
				was_req = reload_req;
				if (line_cnt == 8'd0 || reload_req)
					line_cnt = line_reload;
				else
					line_cnt = line_cnt - 8'd1;
				if ((!cfg_alt_irq || prior != 8'd0 || was_req) && line_cnt == 8'd0 && irq_en)
					irq_flag = 1'b1;
				reload_req = 1'b0;
			end
			a12_prev = pa[12];
			if (!pa[13]) begin
				ca     = pa[12:0];
				ca[12] = ca[12] ^ chr_flip;
				if (!ca[12]) begin
					b   = chr_page[{2'b0, ca[11]}] & 8'hFE;
					off = {b, 10'b0} + 18'(ca[10:0]);
				end else begin
					b   = chr_page[3'd2 + {1'b0, ca[11:10]}];
					off = {b, 10'b0} + 18'(ca[9:0]);
				end
				x.target    = TGT_CHR;
				x.mem_addr  = cfg_chr_ram ? ADDR_W'(off[12:0])
					: ADDR_W'((off & cfg_chr_mask) | cfg_chr_offset);
				x.mem_write = (kind == REQ_PPU_WR) && cfg_chr_ram;
			end
		end
		x.mirror_horizontal = mirror_h;
		x.irq_line          = irq_flag;
		return x;
	endfunction

	function automatic void add_row(bit c, logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] val, req_type_t k, logic [15:0] a, logic [7:0] d,
		bit typed, target_t t, logic [ADDR_W-1:0] ma, logic w, logic m, logic irq);
		stim_row_t r;
		r.cfg_row                = c;
		r.idx                    = idx;
		r.value                  = val;
		r.kind                   = k;
		r.addr                   = a;
		r.data                   = d;
		r.typed                  = typed;
		r.want.target            = t;
		r.want.mem_addr          = ma;
		r.want.mem_write         = w;
		r.want.mirror_horizontal = m;
		r.want.irq_line          = irq;
		plan.push_back(r);
	endfunction

	function automatic void add_access(req_type_t k, logic [15:0] a, logic [7:0] d);
		add_row(1'b0, '0, '0, k, a, d, 1'b0, TGT_NONE, '0, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic void add_checked(req_type_t k, logic [15:0] a, logic [7:0] d,
		target_t t, logic [ADDR_W-1:0] ma, logic w, logic m, logic irq);
		add_row(1'b0, '0, '0, k, a, d, 1'b1, t, ma, w, m, irq);
	endfunction

	function automatic void add_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		add_row(1'b1, idx, val, REQ_CPU_RD, '0, '0, 1'b0, TGT_NONE, '0, 1'b0, 1'b0, 1'b0);
	endfunction

	task automatic send_access(req_type_t k, logic [15:0] a, logic [7:0] d, bit typed,
		xlat_t want);
		int    gap;
		xlat_t got;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid    <= 1'b1;
		req_if.req_type <= k;
		req_if.bus_addr <= a;
		req_if.bus_data <= d;
		do @(posedge clk); while (!req_if.ready);
		got = translate_access(k, a, d);
		xlat_due.push_back(typed ? want : got);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_if.valid     <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.reg_data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_PRG_ROM_MASK:     cfg_prg_mask    = val[PRG_W-1:0];
			CFG_CHR_MEM_MASK:     cfg_chr_mask    = val[CHR_W-1:0];
			CFG_PRG_BANK_COUNT:   cfg_bank_count  = val[CNT_W-1:0];
			CFG_CHR_IS_RAM:       cfg_chr_ram     = val[0];
			CFG_ALT_IRQ:          cfg_alt_irq     = val[0];
			CFG_FOUR_SCREEN:      cfg_four_screen = val[0];
			CFG_PRG_OUTER_OFFSET: cfg_prg_offset  = val[PRG_W-1:0];
			CFG_CHR_OUTER_OFFSET: cfg_chr_offset  = val[CHR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_all(int prg_mask, int chr_mask, int count, int chr_ram,
		int alt, int four, int prg_off, int chr_off);
		write_cfg(CFG_PRG_ROM_MASK, CFG_DATA_W'(prg_mask));
		write_cfg(CFG_CHR_MEM_MASK, CFG_DATA_W'(chr_mask));
		write_cfg(CFG_PRG_BANK_COUNT, CFG_DATA_W'(count));
		write_cfg(CFG_CHR_IS_RAM, CFG_DATA_W'(chr_ram));
		write_cfg(CFG_ALT_IRQ, CFG_DATA_W'(alt));
		write_cfg(CFG_FOUR_SCREEN, CFG_DATA_W'(four));
		write_cfg(CFG_PRG_OUTER_OFFSET, CFG_DATA_W'(prg_off));
		write_cfg(CFG_CHR_OUTER_OFFSET, CFG_DATA_W'(chr_off));
		cfg_if.valid <= 1'b0;
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (xlat_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: check, then pick next ready
	initial begin
		xlat_t want;
		int    hold_left;
		bit    hold_seen;
		hold_left     = 0;
		hold_seen     = 1'b0;
		rsp_if.ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (xlat_due.size() == 0) begin
					$error("result item with no prediction waiting");
					err_cnt++;
				end else begin
					want = xlat_due.pop_front();
					if (rsp_if.target !== want.target) begin
						$error("target: expected %0d, actual %0d", want.target, rsp_if.target);
						err_cnt++;
					end
					if (rsp_if.mem_addr !== want.mem_addr) begin
						$error("mem_addr: expected %0h, actual %0h", want.mem_addr,
							rsp_if.mem_addr);
						err_cnt++;
					end
					if (rsp_if.mem_write !== want.mem_write) begin
						$error("mem_write: expected %0d, actual %0d", want.mem_write,
							rsp_if.mem_write);
						err_cnt++;
					end
					if (rsp_if.mirror_horizontal !== want.mirror_horizontal) begin
						$error("mirror_horizontal: expected %0d, actual %0d",
							want.mirror_horizontal, rsp_if.mirror_horizontal);
						err_cnt++;
					end
					if (rsp_if.irq_line !== want.irq_line) begin
						$error("irq_line: expected %0d, actual %0d", want.irq_line,
							rsp_if.irq_line);
						err_cnt++;
					end
				end
			end
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("bank_switch_mapper_with_line_irq: mismatch");
			$finish;
		end
	end

	initial begin
		req_type_t   k;
		logic [15:0] a;
		logic [7:0]  d;
		xlat_t       blank;
		bit          cfg_open;
		int          ph;
		int          n;
		int          r;
		arst_n           = 1'b0;
		req_if.valid     = 1'b0;
		req_if.req_type  = REQ_CPU_RD;
		req_if.bus_addr  = '0;
		req_if.bus_data  = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.reg_data  = '0;
		cfg_open         = 1'b0;
		blank.target            = TGT_NONE;
		blank.mem_addr          = '0;
		blank.mem_write         = 1'b0;
		blank.mirror_horizontal = 1'b0;
		blank.irq_line          = 1'b0;

		cfg_prg_mask    = PRG_ROM_MASK_RST;
		cfg_chr_mask    = CHR_MEM_MASK_RST;
		cfg_bank_count  = PRG_BANK_COUNT_RST;
		cfg_chr_ram     = 1'b1;
		cfg_alt_irq     = 1'b0;
		cfg_four_screen = 1'b0;
		cfg_prg_offset  = '0;
		cfg_chr_offset  = '0;
		foreach (chr_page[i])
			chr_page[i] = 8'd0;
		prg_page_lo  = 8'd0;
		prg_page_mid = 8'd0;
		page_sel     = 3'd0;
		chr_flip     = 1'b0;
		prg_flip     = 1'b0;
		mirror_h     = 1'b0;
		line_cnt     = 8'd0;
		line_reload  = RELOAD_VALUE_RST;
		irq_en       = 1'b0;
		reload_req   = 1'b0;
		irq_flag     = 1'b0;
		a12_prev     = 1'b0;

		// values straight after reset
		add_checked(REQ_CPU_RD, 16'h0000, 8'h00, TGT_NONE, 21'h0, 1'b0, 1'b0, 1'b0);
		add_checked(REQ_CPU_WR, 16'h6000, 8'hFF, TGT_WRAM, 21'h0, 1'b1, 1'b0, 1'b0);
		add_checked(REQ_CPU_RD, 16'hFFFF, 8'h00, TGT_PRG, 21'h7FFF, 1'b0, 1'b0, 1'b0);
		add_checked(REQ_PPU_RD, 16'h0000, 8'h00, TGT_CHR, 21'h0, 1'b0, 1'b0, 1'b0);
		add_checked(REQ_PPU_WR, 16'h1FFF, 8'h55, TGT_CHR, 21'h3FF, 1'b1, 1'b0, 1'b0);
		add_checked(REQ_PPU_RD, 16'hFFFF, 8'h00, TGT_NONE, 21'h0, 1'b0, 1'b0, 1'b0);
		add_checked(REQ_CPU_WR, 16'hA000, 8'h01, TGT_NONE, 21'h0, 1'b0, 1'b1, 1'b0);
		// swapped layouts, two kilobyte bank low bit
		add_access(REQ_CPU_WR, 16'h8000, 8'hC6);
		add_access(REQ_CPU_WR, 16'h8001, 8'hFF);
		add_access(REQ_CPU_RD, 16'h8000, 8'h00);
		add_access(REQ_CPU_WR, 16'h8000, 8'h00);
		add_access(REQ_CPU_WR, 16'h8001, 8'hFF);
		add_access(REQ_PPU_RD, 16'h0000, 8'h00);
		// reload then count down to an interrupt and acknowledge
		add_access(REQ_CPU_WR, 16'hC000, 8'h01);
		add_access(REQ_CPU_WR, 16'hC001, 8'h00);
		add_access(REQ_CPU_WR, 16'hE001, 8'h00);
		add_access(REQ_PPU_RD, 16'h1000, 8'h00);
		add_access(REQ_PPU_RD, 16'h0000, 8'h00);
		add_access(REQ_PPU_RD, 16'h1000, 8'h00);
		add_access(REQ_CPU_WR, 16'hE000, 8'h00);
		// pattern rom, four screen, older counter rule, bank count wrap
		add_config(CFG_PRG_ROM_MASK, 21'h1FFFFF);
		add_config(CFG_CHR_MEM_MASK, 21'h3FFFF);
		add_config(CFG_PRG_BANK_COUNT, 21'd0);
		add_config(CFG_CHR_IS_RAM, 21'd0);
		add_config(CFG_ALT_IRQ, 21'd1);
		add_config(CFG_FOUR_SCREEN, 21'd1);
		add_config(CFG_PRG_OUTER_OFFSET, 21'h100000);
		add_config(CFG_CHR_OUTER_OFFSET, 21'h20000);
		add_access(REQ_CPU_WR, 16'hC000, 8'h00);
		add_access(REQ_CPU_WR, 16'hE001, 8'h00);
		add_access(REQ_PPU_RD, 16'h0000, 8'h00);
		add_access(REQ_PPU_RD, 16'h1000, 8'h00);
		add_access(REQ_CPU_WR, 16'hC001, 8'h00);
		add_access(REQ_PPU_RD, 16'h0000, 8'h00);
		add_access(REQ_PPU_WR, 16'h1400, 8'hAA);
		add_access(REQ_CPU_WR, 16'hA000, 8'h00);
		add_access(REQ_CPU_RD, 16'hE000, 8'h00);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg_row) begin
				if (!cfg_open) begin
					drain();
					cfg_open = 1'b1;
				end
				write_cfg(plan[i].idx, plan[i].value);
			end else begin
				if (cfg_open) begin
					cfg_if.valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_access(plan[i].kind, plan[i].addr, plan[i].data, plan[i].typed,
					plan[i].want);
			end
		end

		for (ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: program_all(PRG_ROM_MASK_RST, CHR_MEM_MASK_RST, PRG_BANK_COUNT_RST,
					1, 0, 0, 0, 0);
				1: program_all(21'h1FFFFF, 21'h3FFFF, 256, 0, 1, 0, 0, 0);
				2: program_all(0, 0, 2, 0, 0, 1, 21'h1FFFFF, 21'h3FFFF);
				3: program_all(21'h7FFFF, 21'h1FFFF, 1, 1, 1, 1, 0, 0);
				default: program_all((1 << $urandom_range(0, 21)) - 1,
					(1 << $urandom_range(0, 18)) - 1, $urandom_range(0, 511),
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 21'h1FFFFF), $urandom_range(0, 21'h1FFFFF));
			endcase
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 77; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 77; end
				default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase
			if (ph == 4 || ph == 6)
				hold_kick = ~hold_kick;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				d = 8'($urandom_range(0, 255));
				if (r < 8) begin
					// counter and interrupt control, small reload values
					k = REQ_CPU_WR;
					a = {2'b11, 1'($urandom_range(0, 1)), 13'($urandom)};
					if ($urandom_range(0, 1))
						d = 8'($urandom_range(0, 7));
				end else if (r < 25) begin
					k = REQ_CPU_WR;
					a = 16'h8000 | 16'($urandom_range(0, 16'h3FFF));
				end else if (r < 45) begin
					k = REQ_CPU_RD;
					a = 16'($urandom_range(16'h6000, 16'hFFFF));
				end else if (r < 52) begin
					k = $urandom_range(0, 1) ? REQ_CPU_WR : REQ_CPU_RD;
					a = 16'($urandom);
				end else if (r < 92) begin
					k = $urandom_range(0, 1) ? REQ_PPU_WR : REQ_PPU_RD;
					a = 16'($urandom);
				end else begin
					k = req_type_t'(2'($urandom_range(0, 3)));
					a = 16'($urandom);
				end
				send_access(k, a, d, 1'b0, blank);
			end
		end

		drain();
		if (err_cnt == 0 && xlat_due.size() == 0)
			$display("bank_switch_mapper_with_line_irq: match");
		else
			$display("bank_switch_mapper_with_line_irq: mismatch");
		$finish;
	end

endmodule
